/* rtl/cpr_pkg.sv */
package cpr_pkg;

  // Table sizes
  localparam int FRAME_COUNT       = 16;
  localparam int PROCESS_COUNT     = 4;
  localparam int PAGES_PER_PROCESS = 16;
  localparam int PAGE_SLOTS        = PROCESS_COUNT * PAGES_PER_PROCESS;

  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int SLOT_W  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;

  // Fixed field widths of the command and result words
  localparam int PID_FIELD_W   = 2;
  localparam int PAGE_FIELD_W  = 4;
  localparam int FRAME_FIELD_W = 4;

  typedef enum logic {
    CMD_DECLARE = 1'b0,
    CMD_ACCESS  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_FAULT    = 2'd1,
    ST_NOPAGE   = 2'd2,
    ST_DECLARED = 2'd3
  } status_t;

  typedef struct packed {
    command_t                  command;
    logic [PID_FIELD_W-1:0]    process_id;
    logic [PAGE_FIELD_W-1:0]   page_number;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [FRAME_FIELD_W-1:0]  frame_number;
    logic                      needs_writeback;
    logic [PID_FIELD_W-1:0]    victim_process;
    logic [PAGE_FIELD_W-1:0]   victim_page;
  } res_t;

  // One page table entry
  typedef struct packed {
    logic               exists;
    logic               present;
    logic               modified;
    logic [FRAME_W-1:0] frame;
  } page_entry_t;

  // Page table write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    page_entry_t       data;
  } pt_write_t;

  // Page table read request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } pt_read_t;

  // Flat page table index of a (process, page) pair
  function automatic logic [SLOT_W-1:0] slot_index(input logic [PID_FIELD_W-1:0]  pid,
                                                   input logic [PAGE_FIELD_W-1:0] pg);
    int flat;
    flat = int'(pid) * PAGES_PER_PROCESS + int'(pg);
    return SLOT_W'(flat);
  endfunction

  // True when the pair names a page inside the table
  function automatic logic name_in_range(input logic [PID_FIELD_W-1:0]  pid,
                                         input logic [PAGE_FIELD_W-1:0] pg);
    return (int'(pid) < PROCESS_COUNT) && (int'(pg) < PAGES_PER_PROCESS);
  endfunction

endpackage

/* rtl/cpr_page_table.sv */
module cpr_page_table (
  input  logic                 clk,
  input  logic                 rst,
  input  cpr_pkg::pt_read_t    rd,
  output cpr_pkg::page_entry_t rd_data,
  input  cpr_pkg::pt_write_t   wr
);
  import cpr_pkg::*;

  page_entry_t             mem [PAGE_SLOTS];
  logic [PAGE_SLOTS-1:0]   vld;

  // Track which entries have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read; an unwritten entry reads as all zero
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= vld[rd.addr] ? mem[rd.addr] : '0;
    end
  end

endmodule

/* rtl/clock_page_replacement.sv */
// Clock (second chance) page replacement unit.
// Command channel: a word on req is taken at a rising edge with start high and
// busy low. A declare command marks a (process, page) pair as existing; an
// access command looks the page up and, on a fault, picks a victim frame.
// Result channel: one word per command on result, valid for exactly one cycle
// while done is high. The receiver cannot stall; it must take the word then.
// Declare, hit and missing-page answers come from the lookup state. A fault goes
// on to the sweep state, where the hand inspects 1 to FRAME_COUNT+1 frames, one
// per cycle, then to the victim read state if the victim frame has an owner,
// then to the install state. The hand sweep over the referenced bits sets the
// fault time; the page table has a registered read port and a separate write port.
// busy stays high from accept until the cycle done is raised, so one command
// is in flight at a time; the next can be taken at the edge that ends the
// cycle in which done is high.
// Reset (synchronous, rst high) marks every page table entry unwritten (reads
// as nonexistent), clears all referenced bits and frame owners, and returns
// the hand to frame 0. It takes effect at once, with no clearing pass.
module clock_page_replacement (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cpr_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output cpr_pkg::res_t result
);
  import cpr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_LOOKUP  = 5'b00010,
    S_SWEEP   = 5'b00100,
    S_VREAD   = 5'b01000,
    S_INSTALL = 5'b10000
  } state_t;

  state_t                   state;
  logic [FRAME_W-1:0]       hand;
  logic [FRAME_COUNT-1:0]   ref_bits;
  logic [FRAME_COUNT-1:0]   owner_valid;
  logic [PID_FIELD_W-1:0]   owner_pid  [FRAME_COUNT];
  logic [PAGE_FIELD_W-1:0]  owner_page [FRAME_COUNT];

  // Held command
  req_t                     cur;
  logic                     cur_ok;
  logic [SLOT_W-1:0]        cur_idx;

  // Victim bookkeeping
  logic [FRAME_W-1:0]       victim;
  logic [SLOT_W-1:0]        vic_idx;
  logic [PID_FIELD_W-1:0]   vic_pid;
  logic [PAGE_FIELD_W-1:0]  vic_page;
  logic                     vic_wb;

  logic                     accept;
  logic                     hand_ref;
  logic                     take_victim;
  logic [FRAME_W-1:0]       hand_next;
  logic                     done_next;
  res_t                     result_next;
  pt_read_t                 pt_rd;
  pt_write_t                pt_wr;
  page_entry_t              entry;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign hand_ref    = ref_bits[hand];
  assign take_victim = (state == S_SWEEP) && !hand_ref;
  assign hand_next   = (int'(hand) == FRAME_COUNT - 1) ? '0 : hand + FRAME_W'(1);

  // Raise done after a lookup that answers at once, or after an install
  assign done_next = ((state == S_LOOKUP) &&
                      (!cur_ok || cur.command == CMD_DECLARE || !entry.exists ||
                       entry.present)) ||
                     (state == S_INSTALL);

  cpr_page_table u_pt (
    .clk     (clk),
    .rst     (rst),
    .rd      (pt_rd),
    .rd_data (entry),
    .wr      (pt_wr)
  );

  // Issue page table reads: the requested page on accept, the victim's page
  // when the hand stops on an owned frame
  always_comb begin
    pt_rd = '0;
    if (accept) begin
      pt_rd.en   = 1'b1;
      pt_rd.addr = slot_index(req.process_id, req.page_number);
    end else if (take_victim && owner_valid[hand]) begin
      pt_rd.en   = 1'b1;
      pt_rd.addr = slot_index(owner_pid[hand], owner_page[hand]);
    end
  end

  // Drive page table writes
  always_comb begin
    pt_wr = '0;
    case (state)
      S_LOOKUP: begin
        if (cur_ok && cur.command == CMD_DECLARE) begin
          pt_wr.en          = 1'b1;
          pt_wr.addr        = cur_idx;
          pt_wr.data        = entry;
          pt_wr.data.exists = 1'b1;
        end else if (cur_ok && entry.exists && entry.present) begin
          pt_wr.en            = 1'b1;
          pt_wr.addr          = cur_idx;
          pt_wr.data          = entry;
          pt_wr.data.modified = 1'b1;
        end
      end
      S_VREAD: begin
        pt_wr.en          = 1'b1;
        pt_wr.addr        = vic_idx;
        pt_wr.data        = '0;
        pt_wr.data.exists = entry.exists;
      end
      S_INSTALL: begin
        pt_wr.en            = 1'b1;
        pt_wr.addr          = cur_idx;
        pt_wr.data.exists   = 1'b1;
        pt_wr.data.present  = 1'b1;
        pt_wr.data.modified = 1'b0;
        pt_wr.data.frame    = victim;
      end
      default: begin
        pt_wr = '0;
      end
    endcase
  end

  // Build the result word for the cycle that ends a command
  always_comb begin
    result_next = '0;
    case (state)
      S_LOOKUP: begin
        if (!cur_ok) begin
          result_next.status = ST_NOPAGE;
        end else if (cur.command == CMD_DECLARE) begin
          result_next.status = ST_DECLARED;
        end else if (!entry.exists) begin
          result_next.status = ST_NOPAGE;
        end else begin
          result_next.status       = ST_HIT;
          result_next.frame_number = FRAME_FIELD_W'(entry.frame);
        end
      end
      S_INSTALL: begin
        result_next.status          = ST_FAULT;
        result_next.frame_number    = FRAME_FIELD_W'(victim);
        result_next.needs_writeback = vic_wb;
        result_next.victim_process  = vic_pid;
        result_next.victim_page     = vic_page;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // Advance the sequencer and the frame table control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      hand        <= '0;
      ref_bits    <= '0;
      owner_valid <= '0;
      done        <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (!cur_ok || cur.command == CMD_DECLARE || !entry.exists) begin
            state <= S_IDLE;
          end else if (entry.present) begin
            ref_bits[entry.frame] <= 1'b1;
            state                 <= S_IDLE;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          hand <= hand_next;
          if (hand_ref) begin
            ref_bits[hand] <= 1'b0;
          end else if (owner_valid[hand]) begin
            state <= S_VREAD;
          end else begin
            state <= S_INSTALL;
          end
        end
        S_VREAD: begin
          state <= S_INSTALL;
        end
        S_INSTALL: begin
          ref_bits[victim]    <= 1'b1;
          owner_valid[victim] <= 1'b1;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the command word, victim details, frame owners and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      cur     <= req;
      cur_ok  <= name_in_range(req.process_id, req.page_number);
      cur_idx <= slot_index(req.process_id, req.page_number);
    end
    if (take_victim) begin
      victim  <= hand;
      vic_idx <= slot_index(owner_pid[hand], owner_page[hand]);
      vic_wb  <= 1'b0;
      if (owner_valid[hand]) begin
        vic_pid  <= owner_pid[hand];
        vic_page <= owner_page[hand];
      end else begin
        vic_pid  <= '0;
        vic_page <= '0;
      end
    end
    if (state == S_VREAD) begin
      vic_wb <= entry.modified;
    end
    if (state == S_INSTALL) begin
      owner_pid[victim]  <= cur.process_id;
      owner_page[victim] <= cur.page_number;
    end
    result <= result_next;
  end

`ifndef SYNTHESIS
  // A result only follows a cycle in which a command was in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in flight");

  // An accepted command keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // A replaced frame has its referenced bit set when reported
  a_fault_ref: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FAULT) |-> ref_bits[FRAME_W'(result.frame_number)])
    else $error("installed frame is not marked referenced");
`endif

endmodule
